// File: rtl/rwrt_pkg.sv
// shared constants and status codes for the receive window reorder tracker
`default_nettype none

package rwrt_pkg;

  localparam int unsigned DefBufferDepth = 256;
  localparam int unsigned SeqW           = 31;
  localparam int unsigned WinW           = 16;
  localparam int unsigned CntW           = 9;
  localparam int unsigned CntMax         = 511;

  localparam logic [WinW-1:0] WinReset = 16'd64;

  // result status codes
  localparam logic [1:0] StDup    = 2'd0;
  localparam logic [1:0] StStored = 2'd1;
  localparam logic [1:0] StReject = 2'd2;

endpackage

`default_nettype wire

// File: rtl/receive_window_reorder_tracker_unit.sv
// top level: sliding-window receive reorder bitmap with a sequential drain
`default_nettype none

// Tracks arriving packet sequence numbers against the next expected number and a
// circular bitmap of out-of-order arrivals, BUFFER_DEPTH entries deep, held in a
// one-write one-read memory. After reset the block sweeps the memory clear, one
// entry a cycle, with in_stall_o high; configuration writes are taken throughout.
// One word at a time is processed: an old duplicate or a rejected number passes
// through the check and finish states to its result, while a stored number also
// goes through the read and drain states; the drain walks the bitmap memory one
// entry per cycle through its single read port until it meets an entry not set.
// A single 31-bit adder does the window subtraction and the expected-number
// increment. The result sits in an output register, and a new word can be taken
// while it waits. The window is capped at BUFFER_DEPTH.
module receive_window_reorder_tracker_unit
  import rwrt_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = DefBufferDepth
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [WinW-1:0] cfg_wdata_i,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [SeqW-1:0] seq_number_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [1:0]           status_o,
  output logic [SeqW-1:0]      next_expected_o,
  output logic [CntW-1:0]      delivered_count_o
);

  localparam int unsigned SW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_READ,
    S_DRAIN,
    S_FINISH
  } state_e;

  state_e          state_q;
  logic [SeqW-1:0] exp_q;
  logic [SW-1:0]   slot_q;
  logic [CW-1:0]   cnt_q;
  logic [SW-1:0]   clr_q;
  logic [SeqW-1:0] seq_q;
  logic [1:0]      stat_q;
  logic [WinW-1:0] window_q;
  logic            out_valid_q;
  logic [1:0]      out_status_q;
  logic [SeqW-1:0] out_next_q;
  logic [CntW-1:0] out_count_q;

  // bitmap memory
  logic            mem_q [BUFFER_DEPTH];
  logic            rd_q;
  logic            mem_we;
  logic [SW-1:0]   mem_waddr;
  logic            mem_wdata;
  logic [SW-1:0]   mem_raddr;

  // shared adder
  logic [SeqW-1:0] op_a;
  logic [SeqW-1:0] op_b;
  logic [SeqW:0]   sum_w;
  logic [SeqW-1:0] diff;
  logic            seq_ge;

  logic [WinW-1:0] win_eff;
  logic            in_win;
  logic [SW:0]     slot_sum;
  logic [SW-1:0]   seq_slot;
  logic [SW-1:0]   slot_nxt;
  logic            drain_go;
  logic            out_free;
  logic [CntW-1:0] count_sat;

  always_comb begin
    if (state_q == S_CHECK) begin
      op_a = seq_q;
      op_b = ~exp_q;
    end else begin
      op_a = exp_q;
      op_b = '0;
    end
    sum_w = {1'b0, op_a} + {1'b0, op_b} + (SeqW+1)'(1);
  end

  assign diff   = sum_w[SeqW-1:0];
  assign seq_ge = sum_w[SeqW];

  assign win_eff = (32'(window_q) > 32'(BUFFER_DEPTH)) ? WinW'(BUFFER_DEPTH) : window_q;
  assign in_win  = seq_ge && (diff < SeqW'(win_eff));

  // diff is below the depth here, so one compare and subtract wraps the slot
  assign slot_sum = {1'b0, slot_q} + {1'b0, diff[SW-1:0]};
  assign seq_slot = (slot_sum >= (SW+1)'(BUFFER_DEPTH)) ?
                    SW'(slot_sum - (SW+1)'(BUFFER_DEPTH)) : slot_sum[SW-1:0];

  // slot follows expected number, back to zero at the end of the bitmap or when the expected number wraps
  always_comb begin
    if (exp_q == '1) begin
      slot_nxt = '0;
    end else if (slot_q == SW'(BUFFER_DEPTH - 1)) begin
      slot_nxt = '0;
    end else begin
      slot_nxt = slot_q + SW'(1);
    end
  end

  assign drain_go = (state_q == S_DRAIN) && rd_q && (cnt_q != CW'(BUFFER_DEPTH));
  assign out_free = !out_valid_q || !out_stall_i;
  assign count_sat = (32'(cnt_q) > CntMax) ? CntW'(CntMax) : CntW'(cnt_q);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_q;
    mem_wdata = 1'b0;
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
    end else if (state_q == S_CHECK && in_win) begin
      mem_we    = 1'b1;
      mem_waddr = seq_slot;
      mem_wdata = 1'b1;
    end else if (drain_go) begin
      mem_we = 1'b1;
    end
  end

  assign mem_raddr = (state_q == S_DRAIN) ? slot_nxt : slot_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      exp_q        <= '0;
      slot_q       <= '0;
      cnt_q        <= '0;
      clr_q        <= '0;
      seq_q        <= '0;
      stat_q       <= StDup;
      window_q     <= WinReset;
      out_valid_q  <= 1'b0;
      out_status_q <= StDup;
      out_next_q   <= '0;
      out_count_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
      if (state_q == S_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + SW'(1);
          if (clr_q == SW'(BUFFER_DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            seq_q   <= seq_number_i;
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          cnt_q <= '0;
          if (!seq_ge) begin
            stat_q  <= StDup;
            state_q <= S_FINISH;
          end else if (!in_win) begin
            stat_q  <= StReject;
            state_q <= S_FINISH;
          end else begin
            stat_q  <= StStored;
            state_q <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_DRAIN;
        end
        S_DRAIN: begin
          if (drain_go) begin
            exp_q  <= sum_w[SeqW-1:0];
            slot_q <= slot_nxt;
            cnt_q  <= cnt_q + CW'(1);
          end else begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_status_q <= stat_q;
            out_next_q   <= exp_q;
            out_count_q  <= count_sat;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign next_expected_o   = out_next_q;
  assign delivered_count_o = out_count_q;

endmodule

`default_nettype wire

// File: rtl/rwrt_checker.sv
// port-level checks for the receive window reorder tracker, bound to the top level
`default_nettype none

module rwrt_checker
  import rwrt_pkg::*;
(
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            in_valid_i,
  input wire logic            in_stall_o,
  input wire logic            out_valid_o,
  input wire logic            out_stall_i,
  input wire logic [1:0]      status_o,
  input wire logic [SeqW-1:0] next_expected_o,
  input wire logic [CntW-1:0] delivered_count_o
);

  // only a stored word can release packets
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StStored |-> delivered_count_o == '0)
    else $error("packets released by a duplicate or rejected word");

  // one word at a time: after acceptance the input side stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word taken while one is in work");

  // a word that is accepted cannot produce a result in the very next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared before the word was checked");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(next_expected_o) && $stable(delivered_count_o))
    else $error("stalled result changed");

endmodule

bind receive_window_reorder_tracker_unit rwrt_checker u_rwrt_checker (.*);

`default_nettype wire

// File: tb/sv/receive_window_reorder_tracker_unit_test.sv
// testbench for the receive window reorder tracker: random and directed words, scoreboard check
module receive_window_reorder_tracker_unit_test;
  import rwrt_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  class rx_window_scoreboard;
    typedef struct {
      logic [1:0]      status;
      logic [SeqW-1:0] next_exp;
      logic [CntW-1:0] count;
    } outcome_t;

    outcome_t        outcome_q[$];
    bit [WinW-1:0]   window;
    bit [SeqW-1:0]   next_seq;
    bit              held[DefBufferDepth];
    int              errors;

    function new();
      window   = WinReset;
      next_seq = '0;
      foreach (held[i]) held[i] = 1'b0;
      errors   = 0;
    endfunction

    function void set_window(bit [WinW-1:0] value);
      window = value;
    endfunction

    function int unsigned eff_window();
      return (window > DefBufferDepth) ? DefBufferDepth : window;
    endfunction

    function int pending();
      return outcome_q.size();
    endfunction

    // predict the result of one accepted word and update the tracked state
    function void note_word(bit [SeqW-1:0] seq);
      outcome_t    res;
      int unsigned steps;
      longint      span;
      steps = 0;
      span  = longint'(seq) - longint'(next_seq) + 1;
      if (seq < next_seq) begin
        res.status = StDup;
      end else if (span > longint'(eff_window())) begin
        res.status = StReject;
      end else begin
        res.status = StStored;
        held[seq % DefBufferDepth] = 1'b1;
        while (steps < DefBufferDepth && held[next_seq % DefBufferDepth]) begin
          held[next_seq % DefBufferDepth] = 1'b0;
          next_seq = next_seq + 1'b1;
          steps++;
        end
      end
      res.next_exp = next_seq;
      res.count    = CntW'((steps > CntMax) ? CntMax : steps);
      outcome_q    = {outcome_q, res};
    endfunction

    function void check_result(logic [1:0] status, logic [SeqW-1:0] next_exp,
                               logic [CntW-1:0] count);
      outcome_t exp;
      if (outcome_q.size() == 0) begin
        $display("%0t: unexpected result status %0d next %0d count %0d",
                 $time, status, next_exp, count);
        errors++;
        return;
      end
      exp = outcome_q.pop_front();
      if (status !== exp.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp.status, status);
        errors++;
      end
      if (next_exp !== exp.next_exp) begin
        $display("%0t: next_expected expected %0d actual %0d", $time, exp.next_exp, next_exp);
        errors++;
      end
      if (count !== exp.count) begin
        $display("%0t: delivered_count expected %0d actual %0d", $time, exp.count, count);
        errors++;
      end
    endfunction
  endclass

  logic            clk_i        = 1'b0;
  logic            rst_ni       = 1'b0;
  logic            cfg_we_i     = 1'b0;
  logic [WinW-1:0] cfg_wdata_i  = '0;
  logic            in_valid_i   = 1'b0;
  logic            in_stall_o;
  logic [SeqW-1:0] seq_number_i = '0;
  logic            out_valid_o;
  logic            out_stall_i  = 1'b0;
  logic [1:0]      status_o;
  logic [SeqW-1:0] next_expected_o;
  logic [CntW-1:0] delivered_count_o;

  receive_window_reorder_tracker_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .seq_number_i     (seq_number_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .next_expected_o  (next_expected_o),
    .delivered_count_o(delivered_count_o)
  );

  rx_window_scoreboard sb = new();

  int unsigned cycles     = 0;
  int unsigned rx_left    = 0;
  int unsigned rx_mode    = 0;
  int unsigned burst_left = 0;
  bit          sender_idle = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver stall pattern: switches at random between four modes
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= cycles[2];
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(status_o, next_expected_o, delivered_count_o);
    end
  end

  // offer one word, wait for it to be taken, then maybe open a gap
  task automatic send_word(input bit [SeqW-1:0] seq);
    int unsigned gap;
    in_valid_i   <= 1'b1;
    seq_number_i <= seq;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(seq);
    if (sender_idle) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = $urandom_range(1, 8);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic drain_wait();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_window(input bit [WinW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_window(value);
    @(posedge clk_i);
  endtask

  // random words, mostly around the expected number so drains happen
  task automatic run_phase(input bit [WinW-1:0] win, input int unsigned n_words,
                           input bit idle);
    bit [SeqW-1:0] base;
    bit [SeqW-1:0] seq;
    int unsigned   eff;
    int unsigned   kind;
    int unsigned   sent;
    int            n;
    write_window(win);
    sender_idle = idle;
    sent = 0;
    while (sent < n_words) begin
      base = sb.next_seq;
      eff  = sb.eff_window();
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        seq = base;
      end else if (kind < 55) begin
        seq = SeqW'(base + $urandom_range(0, (eff > 8) ? 8 : eff));
      end else if (kind < 65) begin
        seq = SeqW'(base + $urandom_range(0, (eff > 0) ? eff - 1 : 0));
      end else if (kind < 75) begin
        // window edge: last slot inside and first slot outside
        seq = SeqW'(base + eff - 1 + $urandom_range(0, 1));
      end else if (kind < 85) begin
        seq = (base == 0) ? '0 : SeqW'($urandom % base);
      end else if (kind < 93) begin
        seq = SeqW'($urandom);
      end else begin
        // reversed run: with a window of two or more everything lands in the bitmap, the last word drains it
        n = $urandom_range(2, (eff > 12) ? 12 : ((eff < 2) ? 2 : eff));
        for (int k = n - 1; k > 0; k--) send_word(SeqW'(base + k));
        sent += n - 1;
        seq = base;
      end
      send_word(seq);
      sent++;
    end
    drain_wait();
  endtask

  initial begin
    bit [SeqW-1:0] base;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part at the reset window
    send_word(0);
    send_word(0);
    send_word(3);
    send_word(2);
    send_word(1);
    send_word(67);
    send_word(68);
    send_word(31'h7FFF_FFFF);
    send_word(31'h2AAA_AAAA);
    send_word(6);
    send_word(5);
    send_word(4);
    drain_wait();
    // zero window rejects all but old duplicates
    write_window(0);
    send_word(7);
    send_word(3);
    drain_wait();
    write_window(16'hFFFF);
    send_word(262);
    send_word(263);
    drain_wait();
    write_window(1);
    send_word(8);
    send_word(7);
    send_word(8);
    drain_wait();

    // fill the whole bitmap backwards so one word releases the full depth
    write_window(WinW'(DefBufferDepth));
    sender_idle = 1'b1;
    base = sb.next_seq;
    for (int k = DefBufferDepth - 1; k >= 0; k--) send_word(SeqW'(base + k));
    drain_wait();

    run_phase(16'hFFFF, 45, 1'b0);
    run_phase(16'd0, 45, 1'b1);
    run_phase(16'd1, 45, 1'b1);
    run_phase(16'd255, 45, 1'b0);
    run_phase(16'd16, 45, 1'b1);
    run_phase(16'($urandom), 45, 1'b1);
    run_phase(16'd64, 45, 1'b0);
    run_phase(16'd2, 45, 1'b1);
    run_phase(16'($urandom_range(3, 300)), 45, 1'b1);

    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
